// ===== rtl/pcrl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrl_pkg
// Shared types, constants and helpers for the PCR clock recovery loop.
// ----------------------------------------------------------------------------
package pcrl_pkg;

    localparam int PCRL_WINDOW = 64;
    localparam int CW_W        = 48;
    localparam int GAIN_W      = 24;
    localparam int FRAC_W      = 16;
    localparam int PE_W        = 32;
    localparam int NOM_W       = 31;
    localparam int ITEM_W      = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int ACC_W       = 50;

    localparam logic [ITEM_W-1:0] GEAR_ITEM_1 = 15'd175;
    localparam logic [ITEM_W-1:0] GEAR_ITEM_2 = 15'd1000;
    localparam logic [ITEM_W-1:0] GEAR_ITEM_3 = 15'd20000;
    localparam logic [ITEM_W-1:0] ITEM_MAX    = 15'd32767;

    localparam logic [GAIN_W-1:0] GAIN0_RESET = 24'd1677722;
    localparam logic [GAIN_W-1:0] GAIN1_RESET = 24'd167772;
    localparam logic [GAIN_W-1:0] GAIN2_RESET = 24'd16777;
    localparam logic [GAIN_W-1:0] GAIN3_RESET = 24'd1678;

    localparam logic [1:0] LAST_STAGE = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOMINAL   = 3'd0,
        CFG_INIT_COMP = 3'd1,
        CFG_GAIN0     = 3'd2,
        CFG_GAIN1     = 3'd3,
        CFG_GAIN2     = 3'd4,
        CFG_GAIN3     = 3'd5
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SCALE,
        ST_GEAR,
        ST_PHASE,
        ST_INSERT,
        ST_DIV_INIT,
        ST_DIV,
        ST_AVG,
        ST_OUT
    } t_state;

    function automatic logic signed [CW_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = {{(ACC_W-CW_W+1){1'b0}}, {(CW_W-1){1'b1}}};
        lo = {{(ACC_W-CW_W+1){1'b1}}, {(CW_W-1){1'b0}}};
        if (v > hi) begin
            sat48 = hi[CW_W-1:0];
        end else if (v < lo) begin
            sat48 = lo[CW_W-1:0];
        end else begin
            sat48 = v[CW_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/pcrl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pcr_clock_recovery_loop.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_clock_recovery_loop
// One item in flight: phase accumulate, window insert, divide, then gain
// multiply and scale; a gear-shift item first applies the gain to the old
// window average. The next item can be taken in the cycle after the result
// registers. The window average comes from a bit-serial divider, one
// quotient bit per cycle. Reset is synchronous: loop state clears,
// compensation goes to 0, gains to defaults; the window RAM is not cleared.
// ----------------------------------------------------------------------------
module pcr_clock_recovery_loop
    import pcrl_pkg::*;
#(
    parameter int WINDOW = PCRL_WINDOW
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CW_W-1:0]        i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [31:0]            i_pcr_value,
    input  logic [31:0]            i_local_count,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic signed [CW_W-1:0] o_control_word,
    output logic signed [CW_W-1:0] o_filter_average,
    output logic [1:0]             o_gain_stage
);

    localparam int ADDR_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = PE_W + $clog2(WINDOW);
    localparam int DVD_W  = SUM_W + FRAC_W;
    localparam int CNT_W  = $clog2(DVD_W);
    localparam int HALF_W = CW_W / 2;

    t_state r_state, n_state;

    logic [NOM_W-1:0]          r_nominal;
    logic [GAIN_W-1:0]         r_gain [4];
    logic signed [PE_W-1:0]    r_pe;
    logic signed [PE_W-1:0]    r_diff;
    logic signed [SUM_W-1:0]   r_sum;
    logic [FILL_W-1:0]         r_fill;
    logic [ADDR_W-1:0]         r_wp;
    logic signed [CW_W-1:0]    r_comp;
    logic [ITEM_W-1:0]         r_item;
    logic [1:0]                r_stage;
    logic signed [CW_W-1:0]    r_avg;
    logic                      r_gear;
    logic [CW_W-1:0]           r_prod_lo;
    logic [CW_W-1:0]           r_prod_hi;
    logic signed [ACC_W-1:0]   r_scaled;
    logic                      r_neg;
    logic [DVD_W-1:0]          r_dvd;
    logic [FILL_W-1:0]         r_rem;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_out_valid;
    logic signed [CW_W-1:0]    r_out_cw;
    logic signed [CW_W-1:0]    r_out_avg;
    logic [1:0]                r_out_stage;

    logic                      in_acc;
    logic                      gear_item;
    logic                      out_free;
    logic                      full;
    logic                      ram_we;
    logic [PE_W-1:0]           ram_rdata;
    logic [CW_W-1:0]           avg_mag;
    logic [HALF_W-1:0]         mul_a;
    logic [CW_W-1:0]           mul_p;
    logic [CW_W:0]             scale_sum;
    logic signed [PE_W:0]      pe_sum;
    logic signed [PE_W-1:0]    pe_sat;
    logic signed [SUM_W-1:0]   sum_next;
    logic [SUM_W-1:0]          sum_mag;
    logic [FILL_W:0]           rem_sh;
    logic                      q_bit;
    logic [FILL_W:0]           rem_new;
    logic signed [ACC_W-1:0]   cw_acc;
    logic signed [ACC_W-1:0]   comp_acc;

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign gear_item   = (r_item == GEAR_ITEM_1) || (r_item == GEAR_ITEM_2) ||
                         (r_item == GEAR_ITEM_3);
    assign full        = (r_fill == FILL_W'(WINDOW));

    // gain * average, two 24 x 24 partial products through one multiplier
    assign avg_mag   = r_avg[CW_W-1] ? CW_W'(-r_avg) : CW_W'(r_avg);
    assign mul_a     = (r_state == ST_MUL_LO) ? avg_mag[HALF_W-1:0] : avg_mag[CW_W-1:HALF_W];
    assign mul_p     = {{(CW_W-HALF_W){1'b0}}, mul_a} *
                       {{(CW_W-GAIN_W){1'b0}}, r_gain[r_stage]};
    assign scale_sum = {1'b0, r_prod_hi} + (CW_W + 1)'(r_prod_lo[CW_W-1:GAIN_W]);

    // phase error accumulate with saturation
    assign pe_sum = {r_pe[PE_W-1], r_pe} + {r_diff[PE_W-1], r_diff};
    always_comb begin
        if (pe_sum[PE_W] != pe_sum[PE_W-1]) begin
            pe_sat = pe_sum[PE_W] ? {1'b1, {(PE_W-1){1'b0}}} : {1'b0, {(PE_W-1){1'b1}}};
        end else begin
            pe_sat = pe_sum[PE_W-1:0];
        end
    end

    assign sum_next = r_sum + {{(SUM_W-PE_W){r_pe[PE_W-1]}}, r_pe}
                    - (full ? {{(SUM_W-PE_W){ram_rdata[PE_W-1]}}, ram_rdata} : SUM_W'(0));
    assign sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    // restoring divider step
    assign rem_sh  = {r_rem, r_dvd[DVD_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_fill});
    assign rem_new = q_bit ? (rem_sh - {1'b0, r_fill}) : rem_sh;

    assign comp_acc = {{(ACC_W-CW_W){r_comp[CW_W-1]}}, r_comp};
    assign cw_acc   = $signed({{(ACC_W-NOM_W-FRAC_W){1'b0}}, r_nominal, {FRAC_W{1'b0}}})
                    + comp_acc + r_scaled;

    assign ram_we = (r_state == ST_INSERT);

    pcrl_ram #(
        .WIDTH (PE_W),
        .DEPTH (WINDOW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (r_pe),
        .i_raddr (r_wp),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = gear_item ? ST_MUL_LO : ST_PHASE;
                end
            end
            ST_MUL_LO:   n_state = ST_MUL_HI;
            ST_MUL_HI:   n_state = ST_SCALE;
            ST_SCALE:    n_state = r_gear ? ST_GEAR : ST_OUT;
            ST_GEAR:     n_state = ST_PHASE;
            ST_PHASE:    n_state = ST_INSERT;
            ST_INSERT:   n_state = ST_DIV_INIT;
            ST_DIV_INIT: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    n_state = ST_AVG;
                end
            end
            ST_AVG:      n_state = ST_MUL_LO;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal   <= '0;
            r_gain[0]   <= GAIN0_RESET;
            r_gain[1]   <= GAIN1_RESET;
            r_gain[2]   <= GAIN2_RESET;
            r_gain[3]   <= GAIN3_RESET;
            r_pe        <= '0;
            r_sum       <= '0;
            r_fill      <= '0;
            r_wp        <= '0;
            r_comp      <= '0;
            r_item      <= ITEM_W'(1);
            r_stage     <= '0;
            r_avg       <= '0;
            r_gear      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_NOMINAL:   r_nominal <= i_cfg_data[NOM_W-1:0];
                    CFG_INIT_COMP: r_comp    <= i_cfg_data;
                    CFG_GAIN0:     r_gain[0] <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN1:     r_gain[1] <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN2:     r_gain[2] <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN3:     r_gain[3] <= i_cfg_data[GAIN_W-1:0];
                    default:       ;
                endcase
            end

            if (r_out_valid && !i_out_stall && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_diff <= $signed(i_pcr_value - i_local_count);
                        r_gear <= gear_item;
                    end
                end
                ST_MUL_LO: r_prod_lo <= mul_p;
                ST_MUL_HI: r_prod_hi <= mul_p;
                ST_SCALE: begin
                    r_scaled <= r_avg[CW_W-1] ? -$signed({1'b0, scale_sum})
                                              : $signed({1'b0, scale_sum});
                end
                ST_GEAR: begin
                    r_comp <= sat48(comp_acc + r_scaled);
                    if (r_stage != LAST_STAGE) begin
                        r_stage <= r_stage + 2'd1;
                    end
                    r_sum  <= '0;
                    r_fill <= '0;
                    r_wp   <= '0;
                    r_gear <= 1'b0;
                end
                ST_PHASE: r_pe <= pe_sat;
                ST_INSERT: begin
                    r_sum <= sum_next;
                    if (!full) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                    r_wp <= (r_wp == ADDR_W'(WINDOW - 1)) ? '0 : r_wp + ADDR_W'(1);
                end
                ST_DIV_INIT: begin
                    r_neg <= r_sum[SUM_W-1];
                    r_dvd <= {sum_mag, {FRAC_W{1'b0}}};
                    r_rem <= '0;
                    r_cnt <= '0;
                end
                ST_DIV: begin
                    r_rem <= rem_new[FILL_W-1:0];
                    r_dvd <= {r_dvd[DVD_W-2:0], q_bit};
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                ST_AVG: begin
                    r_avg <= r_neg ? -$signed(r_dvd[CW_W-1:0]) : $signed(r_dvd[CW_W-1:0]);
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_cw    <= sat48(cw_acc);
                        r_out_avg   <= r_avg;
                        r_out_stage <= r_stage;
                        if (r_item != ITEM_MAX) begin
                            r_item <= r_item + ITEM_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_control_word   = r_out_cw;
    assign o_filter_average = r_out_avg;
    assign o_gain_stage     = r_out_stage;

endmodule

// ===== tb/pcrl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrl_checker
// Watches the config, item and result channels of the clock recovery loop.
// Keeps its own copy of the loop state (phase error, averaging window, gear
// stage, compensation), works out the control word, window average and gain
// stage for every accepted item, and compares each accepted result in order.
// ----------------------------------------------------------------------------
module pcrl_checker
    import pcrl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CW_W-1:0]        i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [31:0]            i_pcr_value,
    input  logic [31:0]            i_local_count,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic signed [CW_W-1:0] i_control_word,
    input  logic signed [CW_W-1:0] i_filter_average,
    input  logic [1:0]             i_gain_stage,
    output int                     o_errors,
    output int                     o_pending
);

    localparam longint Q48_MAX = (longint'(1) <<< (CW_W - 1)) - 1;
    localparam longint Q48_MIN = -(longint'(1) <<< (CW_W - 1));
    localparam longint PE_MAX  = (longint'(1) <<< (PE_W - 1)) - 1;
    localparam longint PE_MIN  = -(longint'(1) <<< (PE_W - 1));

    typedef struct packed {
        logic signed [CW_W-1:0] word;
        logic signed [CW_W-1:0] avg;
        logic [1:0]             stage;
    } t_loop_out;

    t_loop_out words_due[$];

    logic [NOM_W-1:0]  nom_q;
    logic [GAIN_W-1:0] gain_q [4];
    longint            comp;
    int                pe;
    int                win [PCRL_WINDOW];
    longint            win_sum;
    int                fill;
    int                wpos;
    int                item_no;
    logic [1:0]        stg;
    int                seen;

    function automatic longint clip48(input longint v);
        if (v > Q48_MAX) return Q48_MAX;
        if (v < Q48_MIN) return Q48_MIN;
        return v;
    endfunction

    function automatic longint window_mean();
        if (fill == 0) return 0;
        return (win_sum * 65536) / longint'(fill);
    endfunction

    // product shifted down by 24, rounded toward zero
    function automatic longint apply_gain(input longint a, input logic [GAIN_W-1:0] g);
        logic [63:0] m;
        logic [63:0] p;
        m = (a < 0) ? 64'(-a) : 64'(a);
        p = (m >> 24) * 64'(g) + (((m & 64'hFF_FFFF) * 64'(g)) >> 24);
        return (a < 0) ? -longint'(p) : longint'(p);
    endfunction

    task automatic load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW_W-1:0] d);
        case (idx)
            CFG_NOMINAL:   nom_q = d[NOM_W-1:0];
            CFG_INIT_COMP: comp = $signed(d);
            CFG_GAIN0:     gain_q[0] = d[GAIN_W-1:0];
            CFG_GAIN1:     gain_q[1] = d[GAIN_W-1:0];
            CFG_GAIN2:     gain_q[2] = d[GAIN_W-1:0];
            CFG_GAIN3:     gain_q[3] = d[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic predict_item(input logic [31:0] pcr, input logic [31:0] lcl);
        int        diff;
        longint    acc;
        longint    avg;
        longint    cw;
        t_loop_out e;
        diff = $signed(pcr - lcl);
        // gear shift before the new item
        if (item_no == GEAR_ITEM_1 || item_no == GEAR_ITEM_2 || item_no == GEAR_ITEM_3) begin
            comp = clip48(comp + apply_gain(window_mean(), gain_q[stg]));
            if (stg != LAST_STAGE) stg = stg + 2'd1;
            win_sum = 0;
            fill = 0;
            wpos = 0;
        end
        acc = longint'(pe) + longint'(diff);
        if (acc > PE_MAX) acc = PE_MAX;
        if (acc < PE_MIN) acc = PE_MIN;
        pe = int'(acc);
        fill++;
        if (fill > PCRL_WINDOW) begin
            fill = PCRL_WINDOW;
            win_sum -= win[wpos];
        end
        win[wpos] = pe;
        win_sum += pe;
        wpos = (wpos + 1) % PCRL_WINDOW;
        avg = window_mean();
        cw = clip48(longint'(nom_q) * 65536 + comp + apply_gain(avg, gain_q[stg]));
        e.word  = cw[CW_W-1:0];
        e.avg   = avg[CW_W-1:0];
        e.stage = stg;
        words_due.push_back(e);
        if (item_no < ITEM_MAX) item_no++;
    endtask

    task automatic check_word();
        t_loop_out e;
        seen++;
        if (words_due.size() == 0) begin
            if (o_errors < 10)
                $display("pcrl_chk: result %0d with nothing expected: cw=%0d avg=%0d stage=%0d",
                         seen, i_control_word, i_filter_average, i_gain_stage);
            o_errors++;
            return;
        end
        e = words_due.pop_front();
        if (i_control_word !== e.word || i_filter_average !== e.avg
                || i_gain_stage !== e.stage) begin
            if (o_errors < 10) begin
                $display("pcrl_chk: result %0d mismatch", seen);
                $display("  control_word   exp %0d got %0d", e.word, i_control_word);
                $display("  filter_average exp %0d got %0d", e.avg, i_filter_average);
                $display("  gain_stage     exp %0d got %0d", e.stage, i_gain_stage);
            end
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            nom_q     = '0;
            comp      = 0;
            gain_q[0] = GAIN0_RESET;
            gain_q[1] = GAIN1_RESET;
            gain_q[2] = GAIN2_RESET;
            gain_q[3] = GAIN3_RESET;
            pe        = 0;
            win_sum   = 0;
            fill      = 0;
            wpos      = 0;
            item_no   = 1;
            stg       = 2'd0;
            seen      = 0;
            o_errors  = 0;
            words_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_word();
            if (i_cfg_valid && i_cfg_ready) load_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !i_in_stall) predict_item(i_pcr_value, i_local_count);
        end
        o_pending = words_due.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the clock recovery loop with PCR arrivals: a directed opening at the
// field extremes and the saturation limits, then random phases of jittered
// arrivals between config changes, running through the first gear shifts.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_top
    import pcrl_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam int IDLE_PCT     = 6;
    localparam int RANDOM_ITEMS = 1330;
    localparam logic [CW_W-1:0] Q48_POS_MAX = {1'b0, {(CW_W-1){1'b1}}};
    localparam logic [CW_W-1:0] Q48_NEG_MAX = {1'b1, {(CW_W-1){1'b0}}};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CW_W-1:0]        i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [31:0]            i_pcr_value = '0;
    logic [31:0]            i_local_count = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic signed [CW_W-1:0] o_control_word;
    logic signed [CW_W-1:0] o_filter_average;
    logic [1:0]             o_gain_stage;

    int          errors;
    int          pending;
    int          n_sent = 0;
    int          phase = 0;
    logic        calm = 1'b1;
    logic [31:0] drift = '0;

    pcr_clock_recovery_loop dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_pcr_value      (i_pcr_value),
        .i_local_count    (i_local_count),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_control_word   (o_control_word),
        .o_filter_average (o_filter_average),
        .o_gain_stage     (o_gain_stage)
    );

    pcrl_checker chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_pcr_value      (i_pcr_value),
        .i_local_count    (i_local_count),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_control_word   (o_control_word),
        .i_filter_average (o_filter_average),
        .i_gain_stage     (o_gain_stage),
        .o_errors         (errors),
        .o_pending        (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall = !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    task automatic send_item(input logic [31:0] pcr, input logic [31:0] lcl);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_pcr_value   = pcr;
        i_local_count = lcl;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        n_sent++;
    endtask

    // mostly small jitter around the phase drift, sometimes wide offsets
    task automatic send_jittered_item();
        logic [31:0] pcr;
        logic [31:0] diff;
        int          pick;
        pcr  = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            diff = drift + $urandom_range(0, 8191) - 32'd4096;
        else if (pick < 88)
            diff = drift + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        else
            diff = $urandom;
        send_item(pcr, pcr - diff);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW_W-1:0] d);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [CW_W-1:0] pick_value(input logic [CFG_IDX_W-1:0] idx);
        int                 r;
        logic signed [31:0] s;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return Q48_NEG_MAX;
        if (r == 3) return Q48_POS_MAX;
        case (idx)
            CFG_NOMINAL: return CW_W'($urandom_range(0, 32'h00FF_FFFF));
            CFG_INIT_COMP: begin
                s = $urandom;
                return CW_W'(longint'(s) <<< $urandom_range(0, 12));
            end
            default: return {16'($urandom), 32'($urandom)};
        endcase
    endfunction

    task automatic shuffle_config();
        logic [CFG_IDX_W-1:0] idx;
        repeat ($urandom_range(1, 4)) begin
            idx = CFG_IDX_W'($urandom_range(0, 7));
            write_reg(idx, pick_value(idx));
        end
    endtask

    task automatic run_phase(input int len);
        shuffle_config();
        calm = (phase == 0) || ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 3))
            0: drift = '0;
            1: drift = $urandom_range(0, 255) - 32'd128;
            2: drift = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            default: drift = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
        endcase
        repeat (len) send_jittered_item();
        drain();
        phase++;
    endtask

    initial begin
        int last_random;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults, difference extremes, phase error saturation both ways
        send_item(32'h0000_0000, 32'h0000_0000);
        send_item(32'hFFFF_FFFF, 32'h0000_0000);
        send_item(32'h0000_0000, 32'hFFFF_FFFF);
        repeat (3) send_item(32'h7FFF_FFFF, 32'h0000_0000);
        repeat (3) send_item(32'h0000_0000, 32'h8000_0000);
        send_item(32'h8000_0000, 32'h0000_0000);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // every register at its top, spare indexes ignored
        write_reg(CFG_NOMINAL, '1);
        write_reg(CFG_INIT_COMP, Q48_POS_MAX);
        write_reg(CFG_GAIN0, '1);
        write_reg(CFG_GAIN1, '1);
        write_reg(CFG_GAIN2, '1);
        write_reg(CFG_GAIN3, '1);
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '0);
        repeat (3) send_item(32'h7FFF_FFFF, 32'h0000_0000);
        drain();

        // negative control word saturation
        write_reg(CFG_NOMINAL, '0);
        write_reg(CFG_INIT_COMP, Q48_NEG_MAX);
        repeat (3) send_item(32'h0000_0000, 32'h8000_0000);
        drain();

        // zero gain, compensation reload
        write_reg(CFG_GAIN0, '0);
        write_reg(CFG_INIT_COMP, '0);
        write_reg(CFG_NOMINAL, CW_W'(32'h0000_1000));
        send_item(32'h1234_5678, 32'h1234_0000);
        drain();
        write_reg(CFG_GAIN0, CW_W'(GAIN0_RESET));

        last_random = n_sent + RANDOM_ITEMS;
        while (n_sent < last_random)
            run_phase($urandom_range(30, 150));

        drain();
        repeat (80) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
